[rtl/s2c_pkg.sv]
// Shared types, widths and helpers for the sphere-to-cube mapping block.
package s2c_pkg;

	localparam int FRAC_BITS = 30;
	localparam int COORD_W = 32;
	localparam int AXIS_W = 2;
	localparam int MAG_W = FRAC_BITS + 1;
	localparam int SQ2_W = 2 * MAG_W;
	localparam int P_W = 2 * FRAC_BITS + 4;
	localparam int SQ_R_W = P_W / 2;
	localparam int SQ_REM_W = SQ_R_W + 3;
	localparam int D_W = FRAC_BITS + 4;
	localparam int Q_W = P_W;
	localparam int TH_W = P_W - FRAC_BITS - 1;
	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_AW = 2;

	typedef enum logic [AXIS_W-1:0] {
		AXIS_X = 2'd0,
		AXIS_Y = 2'd1,
		AXIS_Z = 2'd2
	} axis_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] coord_x;
		logic signed [COORD_W-1:0] coord_y;
		logic signed [COORD_W-1:0] coord_z;
	} point_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] cube_x;
		logic signed [COORD_W-1:0] cube_y;
		logic signed [COORD_W-1:0] cube_z;
		logic [AXIS_W-1:0] face_axis;
	} result_t;

	// Classified item: face magnitudes, dominant axis, sign and zero flags
	typedef struct packed {
		logic [MAG_W-1:0] a_mag;
		logic [MAG_W-1:0] b_mag;
		axis_t axis;
		logic [2:0] neg;
		logic [2:0] zero;
	} class_t;

	// Saturate a raw magnitude to one
	function automatic logic [MAG_W-1:0] sat_mag(input logic [COORD_W-1:0] m);
		logic [COORD_W-1:0] one;
		one = COORD_W'(1) << FRAC_BITS;
		return (m > one) ? MAG_W'(one) : MAG_W'(m);
	endfunction

	// Apply sign, or force zero, on a magnitude
	function automatic logic [COORD_W-1:0] put_signed(input logic neg, input logic zero,
			input logic [COORD_W-1:0] m);
		if (zero)
			return '0;
		return neg ? (COORD_W'(0) - m) : m;
	endfunction

endpackage

[rtl/sphere_to_cube_map.sv]
// Top level of the sphere-to-cube mapping block.
//
//  channel  | handshake       | payload
//  ---------+-----------------+------------------------------------------
//  input    | push / full     | point: coord_x, coord_y, coord_z (Q2.30)
//  result   | pop / empty     | result: cube_x, cube_y, cube_z, face_axis
//
// One point enters per cycle while full is low; each result passes through the
// bit-per-stage square root, divider and square root units in series.
// Reset clears the queues and all valid bits; data registers are not reset.
// A full result queue stalls the back pipeline; the front keeps filling its
// four-entry queue and raises full only when that queue is also full.
module sphere_to_cube_map (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	output logic             full,
	input  s2c_pkg::point_t  point,
	output logic             empty,
	input  logic             pop,
	output s2c_pkg::result_t result
);
	import s2c_pkg::*;

	logic f_push, f_full;
	class_t f_item;
	logic b_pop, b_empty;
	class_t b_item;

	s2c_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (full),
		.point  (point),
		.q_push (f_push),
		.q_full (f_full),
		.q_item (f_item)
	);

	s2c_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (f_push),
		.full    (f_full),
		.wr_item (f_item),
		.pop     (b_pop),
		.empty   (b_empty),
		.rd_item (b_item)
	);

	s2c_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_empty (b_empty),
		.q_pop   (b_pop),
		.q_item  (b_item),
		.empty   (empty),
		.pop     (pop),
		.result  (result)
	);

endmodule

[rtl/s2c_sqrt_pipe.sv]
// Pipelined integer square root, one root bit per stage.
module s2c_sqrt_pipe (
	input  logic                      clk,
	input  logic                      en,
	input  logic [s2c_pkg::P_W-1:0]   rad,
	output logic [s2c_pkg::SQ_R_W-1:0] root
);
	import s2c_pkg::*;

	logic [SQ_REM_W-1:0] rem_q [SQ_R_W];
	logic [SQ_R_W-1:0] root_q [SQ_R_W];
	logic [P_W-1:0] rest_q [SQ_R_W];
	logic [SQ_REM_W-1:0] rem_in [SQ_R_W];
	logic [SQ_R_W-1:0] root_in [SQ_R_W];
	logic [P_W-1:0] rest_in [SQ_R_W];

	genvar g;
	generate
		for (g = 0; g < SQ_R_W; g++) begin : g_stage
			logic [SQ_REM_W-1:0] cat;
			logic [SQ_REM_W-1:0] trial;
			logic ge;

			if (g == 0) begin : g_first
				assign rem_in[g] = '0;
				assign root_in[g] = '0;
				assign rest_in[g] = rad;
			end else begin : g_next
				assign rem_in[g] = rem_q[g-1];
				assign root_in[g] = root_q[g-1];
				assign rest_in[g] = rest_q[g-1];
			end

			// Bring down two radicand bits and try the next root bit
			always_comb begin
				cat = {rem_in[g][SQ_REM_W-3:0], rest_in[g][P_W-1 -: 2]};
				trial = {1'b0, root_in[g], 2'b01};
				ge = (cat >= trial);
			end

			always_ff @(posedge clk) begin
				if (en) begin
					rem_q[g] <= ge ? (cat - trial) : cat;
					root_q[g] <= {root_in[g][SQ_R_W-2:0], ge};
					rest_q[g] <= rest_in[g] << 2;
				end
			end
		end
	endgenerate

	assign root = root_q[SQ_R_W-1];

endmodule

[rtl/s2c_div_pipe.sv]
// Pipelined restoring divider: floor(num * 2^FRAC_BITS / den), one bit per stage.
module s2c_div_pipe (
	input  logic                    clk,
	input  logic                    en,
	input  logic [s2c_pkg::P_W-1:0] num,
	input  logic [s2c_pkg::D_W-1:0] den,
	output logic [s2c_pkg::Q_W-1:0] quo
);
	import s2c_pkg::*;

	logic [D_W-1:0] rem_q [Q_W];
	logic [D_W-1:0] den_q [Q_W];
	logic [Q_W-1:0] quo_q [Q_W];
	logic [Q_W-1:0] x_q [Q_W];
	logic [D_W-1:0] rem_in [Q_W];
	logic [D_W-1:0] den_in [Q_W];
	logic [Q_W-1:0] quo_in [Q_W];
	logic [Q_W-1:0] x_in [Q_W];

	genvar g;
	generate
		for (g = 0; g < Q_W; g++) begin : g_stage
			logic [D_W:0] cat;
			logic ge;

			if (g == 0) begin : g_first
				// High part of the scaled dividend is below den
				assign rem_in[g] = D_W'(num[P_W-1:FRAC_BITS+4]);
				assign den_in[g] = den;
				assign quo_in[g] = '0;
				assign x_in[g] = {num[FRAC_BITS+3:0], {FRAC_BITS{1'b0}}};
			end else begin : g_next
				assign rem_in[g] = rem_q[g-1];
				assign den_in[g] = den_q[g-1];
				assign quo_in[g] = quo_q[g-1];
				assign x_in[g] = x_q[g-1];
			end

			// Shift in one dividend bit and subtract when it fits
			always_comb begin
				cat = {rem_in[g], x_in[g][Q_W-1]};
				ge = (cat >= {1'b0, den_in[g]});
			end

			always_ff @(posedge clk) begin
				if (en) begin
					rem_q[g] <= ge ? D_W'(cat - {1'b0, den_in[g]}) : D_W'(cat);
					den_q[g] <= den_in[g];
					quo_q[g] <= {quo_in[g][Q_W-2:0], ge};
					x_q[g] <= x_in[g] << 1;
				end
			end
		end
	endgenerate

	assign quo = quo_q[Q_W-1];

endmodule

[rtl/s2c_front.sv]
// Front end: accept a sphere point, pick the face, saturate and register.
module s2c_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	output logic              full,
	input  s2c_pkg::point_t   point,
	output logic              q_push,
	input  logic              q_full,
	output s2c_pkg::class_t   q_item
);
	import s2c_pkg::*;

	logic [COORD_W-1:0] raw [3];
	logic [COORD_W-1:0] mag [3];
	logic [2:0] neg;
	logic [2:0] zero;
	class_t cls;
	class_t item_s1;
	logic vld_s1;
	logic take;

	// Split each coordinate into sign, zero flag and magnitude
	always_comb begin
		raw[0] = point.coord_x;
		raw[1] = point.coord_y;
		raw[2] = point.coord_z;
		for (int i = 0; i < 3; i++) begin
			neg[i] = raw[i][COORD_W-1];
			zero[i] = (raw[i] == '0);
			mag[i] = neg[i] ? (~raw[i] + COORD_W'(1)) : raw[i];
		end
	end

	// Choose the dominant axis, ties to y then x
	always_comb begin
		cls.neg = neg;
		cls.zero = zero;
		if (mag[1] >= mag[0] && mag[1] >= mag[2]) begin
			cls.axis = AXIS_Y;
			cls.a_mag = sat_mag(mag[0]);
			cls.b_mag = sat_mag(mag[2]);
		end else if (mag[0] >= mag[2]) begin
			cls.axis = AXIS_X;
			cls.a_mag = sat_mag(mag[1]);
			cls.b_mag = sat_mag(mag[2]);
		end else begin
			cls.axis = AXIS_Z;
			cls.a_mag = sat_mag(mag[0]);
			cls.b_mag = sat_mag(mag[1]);
		end
	end

	assign q_push = vld_s1 && !q_full;
	assign full = vld_s1 && q_full;
	assign take = push && !full;
	assign q_item = item_s1;

	// Hold the classified item until the queue takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (!vld_s1 || q_push) begin
			vld_s1 <= take;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			item_s1 <= cls;
		end
	end

endmodule

[rtl/s2c_queue.sv]
// Short queue of classified items between front and back.
module s2c_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	output logic            full,
	input  s2c_pkg::class_t wr_item,
	input  logic            pop,
	output logic            empty,
	output s2c_pkg::class_t rd_item
);
	import s2c_pkg::*;

	class_t mem_q [QUEUE_DEPTH];
	logic [QUEUE_AW-1:0] wr_ptr_q;
	logic [QUEUE_AW-1:0] rd_ptr_q;
	logic [QUEUE_AW:0] cnt_q;
	logic do_push;
	logic do_pop;

	assign full = (cnt_q == (QUEUE_AW+1)'(QUEUE_DEPTH));
	assign empty = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop = pop && !empty;
	assign rd_item = mem_q[rd_ptr_q];

	// Advance pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= wr_ptr_q + QUEUE_AW'(1);
			if (do_pop)
				rd_ptr_q <= rd_ptr_q + QUEUE_AW'(1);
			cnt_q <= cnt_q + (QUEUE_AW+1)'(do_push) - (QUEUE_AW+1)'(do_pop);
		end
	end

	always_ff @(posedge clk) begin
		if (do_push)
			mem_q[wr_ptr_q] <= wr_item;
	end

endmodule

[rtl/s2c_back.sv]
// Back end: nested square roots and divisions, then the result queue.
module s2c_back (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             q_empty,
	output logic             q_pop,
	input  s2c_pkg::class_t  q_item,
	output logic             empty,
	input  logic             pop,
	output s2c_pkg::result_t result
);
	import s2c_pkg::*;

	localparam int TOT = 7 + 2 * SQ_R_W + Q_W;

	typedef struct packed {
		class_t info;
		logic [SQ2_W-1:0] a2;
		logic [SQ2_W-1:0] b2;
		logic [P_W-1:0] tq;
		logic [P_W-1:0] uq;
		logic rneg;
	} side_t;

	logic en;
	logic vld_last;
	logic [TOT-1:0] vld_pipe_q;

	class_t info_s1;
	logic [SQ2_W-1:0] a2_s1, b2_s1;
	side_t side_s2, side_s3, side_s4, side_s5, side_s6;
	side_t side_c4;
	logic [P_W-1:0] r_s3, a6_s3, rad_s4;
	logic [P_W-1:0] tq_c, uq_c;
	logic [TH_W-1:0] th;
	logic [SQ_R_W-1:0] s_root;
	logic [P_W-1:0] num_a_s5, num_b_s5;
	logic [D_W-1:0] den_a_s5, den_b_s5;
	logic [Q_W-1:0] quo_a, quo_b;
	logic [P_W-1:0] rad_a_s6, rad_b_s6;
	logic [SQ_R_W-1:0] root_a, root_b;
	side_t line_a_q [SQ_R_W];
	side_t line_b_q [Q_W];
	side_t line_c_q [SQ_R_W];
	result_t res_c;
	result_t res_s7;
	logic [SQ_R_W-1:0] fa, fb, one_r;

	result_t oq_q [2];
	logic oq_wr_q, oq_rd_q;
	logic [1:0] oq_cnt_q;
	logic oq_full, oq_push, oq_pop;

	// Advance the whole pipeline unless a finished result cannot leave
	assign vld_last = vld_pipe_q[TOT-1];
	assign oq_full = (oq_cnt_q == 2'd2);
	assign en = !(vld_last && oq_full);
	assign q_pop = en && !q_empty;
	assign oq_push = vld_last && en;
	assign oq_pop = pop && !empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_pipe_q <= '0;
		else if (en)
			vld_pipe_q <= {vld_pipe_q[TOT-2:0], q_pop};
	end

	// Stage 1: square the face magnitudes
	always_ff @(posedge clk) begin
		if (en) begin
			info_s1 <= q_item;
			a2_s1 <= SQ2_W'(q_item.a_mag) * SQ2_W'(q_item.a_mag);
			b2_s1 <= SQ2_W'(q_item.b_mag) * SQ2_W'(q_item.b_mag);
		end
	end

	// Stage 2: form t and u
	always_comb begin
		tq_c = (P_W'(3) << (2 * FRAC_BITS)) + (P_W'(a2_s1) << 1) - (P_W'(b2_s1) << 1);
		uq_c = (P_W'(3) << (2 * FRAC_BITS)) + (P_W'(b2_s1) << 1) - (P_W'(a2_s1) << 1);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s2.info <= info_s1;
			side_s2.a2 <= a2_s1;
			side_s2.b2 <= b2_s1;
			side_s2.tq <= tq_c;
			side_s2.uq <= uq_c;
			side_s2.rneg <= 1'b0;
		end
	end

	// Stage 3: square t/2 and form 6a^2
	assign th = TH_W'(side_s2.tq >> (FRAC_BITS + 1));

	always_ff @(posedge clk) begin
		if (en) begin
			side_s3 <= side_s2;
			r_s3 <= P_W'((2 * TH_W)'(th) * (2 * TH_W)'(th));
			a6_s3 <= (P_W'(side_s2.a2) << 2) + (P_W'(side_s2.a2) << 1);
		end
	end

	// Stage 4: inner radicand, clamp to zero when negative
	always_comb begin
		side_c4 = side_s3;
		side_c4.rneg = (r_s3 < a6_s3);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s4 <= side_c4;
			rad_s4 <= (r_s3 < a6_s3) ? '0 : (r_s3 - a6_s3);
		end
	end

	s2c_sqrt_pipe u_sqrt_s (
		.clk  (clk),
		.en   (en),
		.rad  (rad_s4),
		.root (s_root)
	);

	// Delay the side data alongside each pipelined unit
	always_ff @(posedge clk) begin
		if (en) begin
			line_a_q[0] <= side_s4;
			for (int i = 1; i < SQ_R_W; i++)
				line_a_q[i] <= line_a_q[i-1];
			line_b_q[0] <= side_s5;
			for (int i = 1; i < Q_W; i++)
				line_b_q[i] <= line_b_q[i-1];
			line_c_q[0] <= side_s6;
			for (int i = 1; i < SQ_R_W; i++)
				line_c_q[i] <= line_c_q[i-1];
		end
	end

	// Stage 5: rationalized numerators and denominators
	always_ff @(posedge clk) begin
		if (en) begin
			side_s5 <= line_a_q[SQ_R_W-1];
			num_a_s5 <= (P_W'(line_a_q[SQ_R_W-1].a2) << 3) + (P_W'(line_a_q[SQ_R_W-1].a2) << 2);
			num_b_s5 <= (P_W'(line_a_q[SQ_R_W-1].b2) << 3) + (P_W'(line_a_q[SQ_R_W-1].b2) << 2);
			den_a_s5 <= D_W'(line_a_q[SQ_R_W-1].tq >> FRAC_BITS) + (D_W'(s_root) << 1);
			den_b_s5 <= D_W'(line_a_q[SQ_R_W-1].uq >> FRAC_BITS) + (D_W'(s_root) << 1);
		end
	end

	s2c_div_pipe u_div_a (
		.clk (clk),
		.en  (en),
		.num (num_a_s5),
		.den (den_a_s5),
		.quo (quo_a)
	);

	s2c_div_pipe u_div_b (
		.clk (clk),
		.en  (en),
		.num (num_b_s5),
		.den (den_b_s5),
		.quo (quo_b)
	);

	// Stage 6: pick the outer radicands
	always_ff @(posedge clk) begin
		if (en) begin
			side_s6 <= line_b_q[Q_W-1];
			rad_a_s6 <= line_b_q[Q_W-1].rneg ? (line_b_q[Q_W-1].tq >> 1) : P_W'(quo_a);
			rad_b_s6 <= line_b_q[Q_W-1].rneg ? (line_b_q[Q_W-1].uq >> 1) : P_W'(quo_b);
		end
	end

	s2c_sqrt_pipe u_sqrt_a (
		.clk  (clk),
		.en   (en),
		.rad  (rad_a_s6),
		.root (root_a)
	);

	s2c_sqrt_pipe u_sqrt_b (
		.clk  (clk),
		.en   (en),
		.rad  (rad_b_s6),
		.root (root_b)
	);

	// Stage 7: saturate, restore signs and undo the permutation
	always_comb begin
		one_r = SQ_R_W'(1) << FRAC_BITS;
		fa = (root_a > one_r) ? one_r : root_a;
		fb = (root_b > one_r) ? one_r : root_b;
	end

	always_comb begin
		res_c = '0;
		case (line_c_q[SQ_R_W-1].info.axis)
			AXIS_X: begin
				res_c.cube_x = put_signed(line_c_q[SQ_R_W-1].info.neg[0],
					line_c_q[SQ_R_W-1].info.zero[0], COORD_W'(one_r));
				res_c.cube_y = put_signed(line_c_q[SQ_R_W-1].info.neg[1],
					line_c_q[SQ_R_W-1].info.zero[1], COORD_W'(fa));
				res_c.cube_z = put_signed(line_c_q[SQ_R_W-1].info.neg[2],
					line_c_q[SQ_R_W-1].info.zero[2], COORD_W'(fb));
				res_c.face_axis = AXIS_X;
			end
			AXIS_Y: begin
				res_c.cube_x = put_signed(line_c_q[SQ_R_W-1].info.neg[0],
					line_c_q[SQ_R_W-1].info.zero[0], COORD_W'(fa));
				res_c.cube_y = put_signed(line_c_q[SQ_R_W-1].info.neg[1],
					line_c_q[SQ_R_W-1].info.zero[1], COORD_W'(one_r));
				res_c.cube_z = put_signed(line_c_q[SQ_R_W-1].info.neg[2],
					line_c_q[SQ_R_W-1].info.zero[2], COORD_W'(fb));
				res_c.face_axis = AXIS_Y;
			end
			default: begin
				res_c.cube_x = put_signed(line_c_q[SQ_R_W-1].info.neg[0],
					line_c_q[SQ_R_W-1].info.zero[0], COORD_W'(fa));
				res_c.cube_y = put_signed(line_c_q[SQ_R_W-1].info.neg[1],
					line_c_q[SQ_R_W-1].info.zero[1], COORD_W'(fb));
				res_c.cube_z = put_signed(line_c_q[SQ_R_W-1].info.neg[2],
					line_c_q[SQ_R_W-1].info.zero[2], COORD_W'(one_r));
				res_c.face_axis = AXIS_Z;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (en)
			res_s7 <= res_c;
	end

	// Two-entry result queue decouples the pipeline from the consumer
	assign empty = (oq_cnt_q == 2'd0);
	assign result = oq_q[oq_rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			oq_wr_q <= 1'b0;
			oq_rd_q <= 1'b0;
			oq_cnt_q <= 2'd0;
		end else begin
			if (oq_push)
				oq_wr_q <= !oq_wr_q;
			if (oq_pop)
				oq_rd_q <= !oq_rd_q;
			oq_cnt_q <= oq_cnt_q + 2'(oq_push) - 2'(oq_pop);
		end
	end

	always_ff @(posedge clk) begin
		if (oq_push)
			oq_q[oq_wr_q] <= res_s7;
	end

	a_oq_bound: assert property (@(posedge clk) disable iff (!arst_n)
		oq_cnt_q != 2'd3) else $error("result queue count out of range");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!en |-> (vld_last && oq_full)) else $error("pipeline stalled without a blocked result");

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		oq_push |-> !oq_full) else $error("result pushed into a full queue");

	a_axis_legal: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (result.face_axis != 2'd3)) else $error("illegal face axis on output");

endmodule
